@@ src/one_edit_keyboard_match_core_macros.svh @@
// Assertion macros for the one-edit keyboard match RTL.
`ifndef ONE_EDIT_KEYBOARD_MATCH_CORE_MACROS_SVH
`define ONE_EDIT_KEYBOARD_MATCH_CORE_MACROS_SVH

// same-cycle implication
`define OEKM_ASSERT_IMP(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
		else $error("oekm: implication failed");

// next-cycle implication
`define OEKM_ASSERT_NEXT(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
		else $error("oekm: next-cycle implication failed");

`endif

@@ src/oekm_pkg.sv @@
// Types, constants and keyboard grid lookup for the one-edit keyboard match block.
package oekm_pkg;

	localparam int BYTE_W = 8;
	localparam int TEXT_W = 64;
	localparam int LEN_W  = 4;
	localparam int REL_W  = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [REL_W-1:0]  relation_t;

	localparam relation_t REL_NONE      = 2'd0;
	localparam relation_t REL_EXACT     = 2'd1;
	localparam relation_t REL_CORRECTED = 2'd2;

	localparam byte_t CH_L = 8'h6C;
	localparam byte_t CH_N = 8'h6E;
	localparam byte_t CH_F = 8'h66;
	localparam byte_t CH_H = 8'h68;

	typedef struct packed {
		logic diff;
		logic sub;
		logic swap;
		logic eq0;
		logic eq1;
	} lane_flags_t;

	typedef struct packed {
		logic same;
		logic off_one;
	} len_info_t;

	typedef struct packed {
		logic       found;
		logic [1:0] row;
		logic [4:0] col;
	} grid_pos_t;

	// staggered grid: col = index*2 + row
	function automatic grid_pos_t grid_lookup(input byte_t ch);
		grid_pos_t p;
		p = '{found: 1'b1, row: 2'd0, col: 5'd0};
		case (ch)
			8'h71: begin p.row = 2'd0; p.col = 5'd0;  end // q
			8'h77: begin p.row = 2'd0; p.col = 5'd2;  end // w
			8'h65: begin p.row = 2'd0; p.col = 5'd4;  end // e
			8'h72: begin p.row = 2'd0; p.col = 5'd6;  end // r
			8'h74: begin p.row = 2'd0; p.col = 5'd8;  end // t
			8'h79: begin p.row = 2'd0; p.col = 5'd10; end // y
			8'h75: begin p.row = 2'd0; p.col = 5'd12; end // u
			8'h69: begin p.row = 2'd0; p.col = 5'd14; end // i
			8'h6F: begin p.row = 2'd0; p.col = 5'd16; end // o
			8'h70: begin p.row = 2'd0; p.col = 5'd18; end // p
			8'h61: begin p.row = 2'd1; p.col = 5'd1;  end // a
			8'h73: begin p.row = 2'd1; p.col = 5'd3;  end // s
			8'h64: begin p.row = 2'd1; p.col = 5'd5;  end // d
			8'h66: begin p.row = 2'd1; p.col = 5'd7;  end // f
			8'h67: begin p.row = 2'd1; p.col = 5'd9;  end // g
			8'h68: begin p.row = 2'd1; p.col = 5'd11; end // h
			8'h6A: begin p.row = 2'd1; p.col = 5'd13; end // j
			8'h6B: begin p.row = 2'd1; p.col = 5'd15; end // k
			8'h6C: begin p.row = 2'd1; p.col = 5'd17; end // l
			8'h7A: begin p.row = 2'd2; p.col = 5'd2;  end // z
			8'h78: begin p.row = 2'd2; p.col = 5'd4;  end // x
			8'h63: begin p.row = 2'd2; p.col = 5'd6;  end // c
			8'h76: begin p.row = 2'd2; p.col = 5'd8;  end // v
			8'h62: begin p.row = 2'd2; p.col = 5'd10; end // b
			8'h6E: begin p.row = 2'd2; p.col = 5'd12; end // n
			8'h6D: begin p.row = 2'd2; p.col = 5'd14; end // m
			default: p.found = 1'b0;
		endcase
		return p;
	endfunction

	function automatic logic sub_ok(input byte_t e, input byte_t a);
		grid_pos_t  pe;
		grid_pos_t  pa;
		logic [1:0] dr;
		logic [4:0] dc;
		logic       pair;
		pe   = grid_lookup(e);
		pa   = grid_lookup(a);
		dr   = (pe.row >= pa.row) ? (pe.row - pa.row) : (pa.row - pe.row);
		dc   = (pe.col >= pa.col) ? (pe.col - pa.col) : (pa.col - pe.col);
		pair = (e == CH_L && a == CH_N) || (e == CH_N && a == CH_L) ||
			(e == CH_F && a == CH_H) || (e == CH_H && a == CH_F);
		return pair || (pe.found && pa.found && dr <= 2'd1 && dc <= 5'd2);
	endfunction

endpackage

@@ src/oekm_if.sv @@
// Request and response channel interfaces of the one-edit keyboard match block.
interface oekm_req_if;
	logic                          valid;
	logic                          ready;
	logic [oekm_pkg::TEXT_W-1:0]   expected_text;
	oekm_pkg::len_t                expected_length;
	logic [oekm_pkg::TEXT_W-1:0]   actual_text;
	oekm_pkg::len_t                actual_length;

	modport source (output valid, expected_text, expected_length, actual_text,
		actual_length, input ready);
	modport sink (input valid, expected_text, expected_length, actual_text,
		actual_length, output ready);
endinterface

interface oekm_rsp_if;
	logic                valid;
	logic                ready;
	oekm_pkg::relation_t relation;

	modport source (output valid, relation, input ready);
	modport sink (input valid, relation, output ready);
endinterface

@@ src/oekm_lane.sv @@
// One byte-position lane: mismatch, substitution, swap, straight-compare and shifted-compare flags.
module oekm_lane #(
	parameter int IDX = 0
) (
	input  oekm_pkg::byte_t       e_byte,
	input  oekm_pkg::byte_t       a_byte,
	input  oekm_pkg::byte_t       e_next,
	input  oekm_pkg::byte_t       a_next,
	input  oekm_pkg::len_t        el,
	input  oekm_pkg::len_t        sl,
	input  logic                  exp_longer,
	output oekm_pkg::lane_flags_t flags
);
	localparam logic [oekm_pkg::LEN_W:0] POS      = (oekm_pkg::LEN_W+1)'(IDX);
	localparam logic [oekm_pkg::LEN_W:0] POS_NEXT = (oekm_pkg::LEN_W+1)'(IDX + 1);

	logic in_e;
	logic in_e_next;
	logic in_s;
	logic shift_eq;

	always_comb begin
		in_e      = {1'b0, el} > POS;
		in_e_next = {1'b0, el} > POS_NEXT;
		in_s      = {1'b0, sl} > POS;
		shift_eq  = exp_longer ? (e_next == a_byte) : (a_next == e_byte);

		flags.diff = in_e && (e_byte != a_byte);
		flags.sub  = oekm_pkg::sub_ok(e_byte, a_byte);
		flags.swap = in_e_next && (e_byte == a_next) && (e_next == a_byte);
		flags.eq0  = !in_s || (e_byte == a_byte);
		flags.eq1  = !in_s || shift_eq;
	end
endmodule

@@ src/oekm_merge.sv @@
// Merging stage: combines lane flags into the relation code.
module oekm_merge #(
	parameter int LANES = 8
) (
	input  oekm_pkg::lane_flags_t [LANES-1:0] flags,
	input  oekm_pkg::len_info_t               len,
	output oekm_pkg::relation_t               relation
);
	logic [LANES-1:0] diff;
	logic [LANES-1:0] sub;
	logic [LANES-1:0] swap;
	logic [LANES-1:0] eq0;
	logic [LANES-1:0] eq1;
	logic [LANES:0]   pre;
	logic [LANES:0]   suf;
	logic [LANES-1:0] pair;
	logic             swap_hit;
	logic             del_hit;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			diff[i] = flags[i].diff;
			sub[i]  = flags[i].sub;
			swap[i] = flags[i].swap;
			eq0[i]  = flags[i].eq0;
			eq1[i]  = flags[i].eq1;
		end

		// prefix of straight matches, suffix of shifted matches
		pre[0]     = 1'b1;
		suf[LANES] = 1'b1;
		for (int k = 0; k < LANES; k++)
			pre[k+1] = pre[k] && eq0[k];
		for (int k = LANES - 1; k >= 0; k--)
			suf[k] = suf[k+1] && eq1[k];
		del_hit = |(pre & suf);

		swap_hit = 1'b0;
		for (int j = 0; j < LANES - 1; j++) begin
			pair        = '0;
			pair[j]     = 1'b1;
			pair[j+1]   = 1'b1;
			swap_hit    = swap_hit || ((diff == pair) && swap[j]);
		end

		relation = oekm_pkg::REL_NONE;
		if (len.same) begin
			if (diff == '0)
				relation = oekm_pkg::REL_EXACT;
			else if (($countones(diff) == 1 && |(diff & sub)) || swap_hit)
				relation = oekm_pkg::REL_CORRECTED;
		end else if (len.off_one && del_hit) begin
			relation = oekm_pkg::REL_CORRECTED;
		end
	end
endmodule

@@ src/one_edit_keyboard_match_core.sv @@
// Top level of the one-edit keyboard match block.
// Requests arrive on req: an expected word and a typed word of up to MAX_CHARS
// bytes each, byte 0 in the low bits, with a length field each; lengths above
// MAX_CHARS count as MAX_CHARS and bytes past a length are ignored.
// Each request yields one response on rsp carrying relation: none, exact match
// or corrected by one allowed edit (keyboard-neighbour substitution, adjacent
// swap, or one byte more or less).
// One lane per byte position compares the words; the lane flags are
// registered and a merging stage forms the relation into the output register.
// Pipeline: two register stages, the lane-flag register and then the output
// register; a stalled output holds a request in the lane stage.
// Throughput: one request per cycle while rsp.ready does not stall the output.
// A stalled response holds in the output register; the lane stage keeps
// taking a request while it is empty, so ready drops only when both stages
// hold work and rsp.ready is low.
// Reset clears both stage valid flags; the data registers are not reset.
`include "one_edit_keyboard_match_core_macros.svh"

module one_edit_keyboard_match_core #(
	parameter int MAX_CHARS = 8
) (
	input logic      clk,
	input logic      arst_n,
	oekm_req_if.sink   req,
	oekm_rsp_if.source rsp
);
	localparam int LANES = MAX_CHARS;
	localparam int BW    = oekm_pkg::BYTE_W;

	oekm_pkg::len_t      el_c;
	oekm_pkg::len_t      al_c;
	oekm_pkg::len_t      sl_c;
	logic                exp_longer;
	oekm_pkg::len_info_t len_d;

	oekm_pkg::lane_flags_t [LANES-1:0] flags_d;
	oekm_pkg::lane_flags_t [LANES-1:0] flags_s1;
	oekm_pkg::len_info_t               len_s1;
	logic                              valid_s1;
	logic                              s1_move;
	logic [LANES-1:0]                  diff_s1;
	oekm_pkg::relation_t               rel_d;
	logic                              out_valid_q;
	oekm_pkg::relation_t               relation_q;

	always_comb begin
		el_c = (req.expected_length > oekm_pkg::LEN_W'(MAX_CHARS)) ?
			oekm_pkg::LEN_W'(MAX_CHARS) : req.expected_length;
		al_c = (req.actual_length > oekm_pkg::LEN_W'(MAX_CHARS)) ?
			oekm_pkg::LEN_W'(MAX_CHARS) : req.actual_length;
		exp_longer    = el_c > al_c;
		sl_c          = exp_longer ? al_c : el_c;
		len_d.same    = el_c == al_c;
		len_d.off_one = ({1'b0, el_c} + 5'd1 == {1'b0, al_c}) ||
			({1'b0, al_c} + 5'd1 == {1'b0, el_c});
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		oekm_pkg::byte_t e_next;
		oekm_pkg::byte_t a_next;
		if (i + 1 < LANES) begin : g_next
			assign e_next = req.expected_text[(i+1)*BW +: BW];
			assign a_next = req.actual_text[(i+1)*BW +: BW];
		end else begin : g_last
			assign e_next = '0;
			assign a_next = '0;
		end
		oekm_lane #(.IDX(i)) u_lane (
			.e_byte     (req.expected_text[i*BW +: BW]),
			.a_byte     (req.actual_text[i*BW +: BW]),
			.e_next     (e_next),
			.a_next     (a_next),
			.el         (el_c),
			.sl         (sl_c),
			.exp_longer (exp_longer),
			.flags      (flags_d[i])
		);
		assign diff_s1[i] = flags_s1[i].diff;
	end

	assign s1_move   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			flags_s1 <= flags_d;
			len_s1   <= len_d;
		end
	end

	oekm_merge #(.LANES(LANES)) u_merge (
		.flags    (flags_s1),
		.len      (len_s1),
		.relation (rel_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_move)
			relation_q <= rel_d;
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.relation = relation_q;

	`OEKM_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, valid_s1)
	`OEKM_ASSERT_NEXT(a_s1_drains_to_out, clk, arst_n, valid_s1 && s1_move, rsp.valid)
	`OEKM_ASSERT_IMP(a_empty_stage_ready, clk, arst_n, !valid_s1, req.ready)
	`OEKM_ASSERT_IMP(a_exact_needs_match, clk, arst_n,
		valid_s1 && rel_d == oekm_pkg::REL_EXACT, len_s1.same && diff_s1 == '0)
	`OEKM_ASSERT_IMP(a_relation_code, clk, arst_n, rsp.valid,
		rsp.relation == oekm_pkg::REL_NONE || rsp.relation == oekm_pkg::REL_EXACT ||
		rsp.relation == oekm_pkg::REL_CORRECTED)
endmodule

@@ verif/one_edit_keyboard_match_core_tb.sv @@
// Self-checking testbench for one_edit_keyboard_match_core: predicted relation per request.
`timescale 1ns / 100ps

module one_edit_keyboard_match_core_tb;

	localparam int WORD_MAX    = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQS = 650;

	typedef struct {
		logic [oekm_pkg::TEXT_W-1:0] et;
		oekm_pkg::len_t              el;
		logic [oekm_pkg::TEXT_W-1:0] at;
		oekm_pkg::len_t              al;
	} word_pair_t;

	class relation_scoreboard;
		oekm_pkg::relation_t pending_relations[$];
		int                  fail_count = 0;
		string               key_rows[3] = '{"qwertyuiop", "asdfghjkl", "zxcvbnm"};

		function oekm_pkg::byte_t byte_of(logic [oekm_pkg::TEXT_W-1:0] w, int i);
			return w[8*i +: 8];
		endfunction

		function bit key_spot(oekm_pkg::byte_t ch, output int row, output int col);
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < key_rows[r].len(); k++) begin
					if (oekm_pkg::byte_t'(key_rows[r][k]) == ch) begin
						row = r;
						col = k * 2 + r;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function bit substitution_ok(oekm_pkg::byte_t e, oekm_pkg::byte_t a);
			int re, ce, ra, ca, dr, dc;
			if ((e == "l" && a == "n") || (e == "n" && a == "l") ||
				(e == "f" && a == "h") || (e == "h" && a == "f"))
				return 1'b1;
			if (!key_spot(e, re, ce) || !key_spot(a, ra, ca))
				return 1'b0;
			dr = (re > ra) ? re - ra : ra - re;
			dc = (ce > ca) ? ce - ca : ca - ce;
			return dr <= 1 && dc <= 2;
		endfunction

		function oekm_pkg::relation_t predict_relation(word_pair_t p);
			int el, al, diffs, first, second, li, si, ll, sl;
			bit skipped;
			logic [oekm_pkg::TEXT_W-1:0] lw, sw;
			el = (p.el > WORD_MAX) ? WORD_MAX : int'(p.el);
			al = (p.al > WORD_MAX) ? WORD_MAX : int'(p.al);
			if (el == al) begin
				diffs = 0;
				first = 0;
				second = 0;
				for (int i = 0; i < el; i++) begin
					if (byte_of(p.et, i) != byte_of(p.at, i)) begin
						if (diffs == 0)
							first = i;
						else if (diffs == 1)
							second = i;
						diffs++;
					end
				end
				if (diffs == 0)
					return oekm_pkg::REL_EXACT;
				if (diffs == 1 && substitution_ok(byte_of(p.et, first), byte_of(p.at, first)))
					return oekm_pkg::REL_CORRECTED;
				if (diffs == 2 && second == first + 1 &&
					byte_of(p.et, first) == byte_of(p.at, second) &&
					byte_of(p.et, second) == byte_of(p.at, first))
					return oekm_pkg::REL_CORRECTED;
				return oekm_pkg::REL_NONE;
			end
			if (el + 1 != al && al + 1 != el)
				return oekm_pkg::REL_NONE;
			lw = (el > al) ? p.et : p.at;
			sw = (el > al) ? p.at : p.et;
			ll = (el > al) ? el : al;
			sl = (el > al) ? al : el;
			li = 0;
			si = 0;
			skipped = 1'b0;
			while (li < ll && si < sl) begin
				if (byte_of(lw, li) == byte_of(sw, si)) begin
					li++;
					si++;
				end else if (!skipped) begin
					skipped = 1'b1;
					li++;
				end else begin
					return oekm_pkg::REL_NONE;
				end
			end
			return oekm_pkg::REL_CORRECTED;
		endfunction

		function void note_request(word_pair_t p);
			pending_relations.insert(pending_relations.size(), predict_relation(p));
		endfunction

		function void check_response(oekm_pkg::relation_t got);
			oekm_pkg::relation_t want;
			if (pending_relations.size() == 0) begin
				$error("relation: expected nothing, actual %0d", got);
				fail_count++;
				return;
			end
			want = pending_relations.pop_front();
			if (got !== want) begin
				$error("relation: expected %0d, actual %0d", want, got);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	oekm_req_if req_ch ();
	oekm_rsp_if rsp_ch ();

	one_edit_keyboard_match_core #(
		.MAX_CHARS(WORD_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	relation_scoreboard sb = new();
	bit idling_on     = 1'b1;
	bit long_hold_due = 1'b0;
	string key_letters = "qwertyuiopasdfghjklzxcvbnm";

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		word_pair_t seen;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				seen.et = req_ch.expected_text;
				seen.el = req_ch.expected_length;
				seen.at = req_ch.actual_text;
				seen.al = req_ch.actual_length;
				sb.note_request(seen);
			end
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.relation);
		end
	end

	// response side: random short stalls plus one long hold-off on demand
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_due) begin
				long_hold_due = 1'b0;
				hold_left = 59;
				rsp_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic drive_request(word_pair_t p);
		req_ch.valid           <= 1'b1;
		req_ch.expected_text   <= p.et;
		req_ch.expected_length <= p.el;
		req_ch.actual_text     <= p.at;
		req_ch.actual_length   <= p.al;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic sender_gap(int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_relations.size() != 0)
			@(posedge clk);
	endtask

	task automatic maybe_gap();
		if (idling_on && $urandom_range(0, 4) == 0)
			sender_gap($urandom_range(1, 3));
	endtask

	function automatic logic [oekm_pkg::TEXT_W-1:0] pack_text(string s);
		logic [oekm_pkg::TEXT_W-1:0] w;
		w = {$urandom, $urandom};
		for (int i = 0; i < s.len() && i < WORD_MAX; i++)
			w[8*i +: 8] = s[i];
		return w;
	endfunction

	task automatic send_words(string e, string a);
		word_pair_t p;
		p.et = pack_text(e);
		p.el = oekm_pkg::len_t'(e.len());
		p.at = pack_text(a);
		p.al = oekm_pkg::len_t'(a.len());
		drive_request(p);
		maybe_gap();
	endtask

	task automatic send_raw(logic [oekm_pkg::TEXT_W-1:0] et, oekm_pkg::len_t el,
		logic [oekm_pkg::TEXT_W-1:0] at, oekm_pkg::len_t al);
		word_pair_t p;
		p.et = et;
		p.el = el;
		p.at = at;
		p.al = al;
		drive_request(p);
		maybe_gap();
	endtask

	function automatic oekm_pkg::byte_t random_char();
		if ($urandom_range(0, 7) == 0)
			return oekm_pkg::byte_t'($urandom_range(0, 255));
		return key_letters[$urandom_range(0, 25)];
	endfunction

	function automatic oekm_pkg::byte_t swapped_in(oekm_pkg::byte_t c);
		case ($urandom_range(0, 3))
			0: begin
				if (c == "l") return "n";
				if (c == "n") return "l";
				if (c == "f") return "h";
				if (c == "h") return "f";
				return random_char();
			end
			1: return random_char();
			default: return key_letters[$urandom_range(0, 25)];
		endcase
	endfunction

	function automatic oekm_pkg::len_t code_length(int n);
		if (n == WORD_MAX && $urandom_range(0, 2) == 0)
			return oekm_pkg::len_t'($urandom_range(WORD_MAX, 15));
		return oekm_pkg::len_t'(n);
	endfunction

	// well-formed edit of a random word, with some noise mixed in
	function automatic word_pair_t make_pair();
		word_pair_t p;
		oekm_pkg::byte_t eb[WORD_MAX];
		oekm_pkg::byte_t ab[WORD_MAX];
		int n, m, pos, pos2;
		oekm_pkg::byte_t tmp;
		n = $urandom_range(0, WORD_MAX);
		foreach (eb[i]) eb[i] = random_char();
		ab = eb;
		m = n;
		case ($urandom_range(0, 9))
			0, 1: ;
			2, 3: if (n > 0) begin
				pos = $urandom_range(0, n - 1);
				ab[pos] = swapped_in(eb[pos]);
			end
			4: if (n >= 2) begin
				pos = $urandom_range(0, n - 2);
				tmp = ab[pos];
				ab[pos] = ab[pos + 1];
				ab[pos + 1] = tmp;
			end
			5: if (n >= 1) begin
				pos = $urandom_range(0, n - 1);
				for (int i = pos; i < WORD_MAX - 1; i++) ab[i] = eb[i + 1];
				m = n - 1;
			end
			6: if (n < WORD_MAX) begin
				pos = $urandom_range(0, n);
				for (int i = WORD_MAX - 1; i > pos; i--) ab[i] = eb[i - 1];
				ab[pos] = random_char();
				m = n + 1;
			end
			7: if (n > 0) begin
				pos = $urandom_range(0, n - 1);
				pos2 = $urandom_range(0, n - 1);
				ab[pos] = swapped_in(eb[pos]);
				ab[pos2] = swapped_in(eb[pos2]);
			end
			8: begin
				foreach (ab[i]) ab[i] = random_char();
				m = $urandom_range(0, WORD_MAX);
			end
			default: begin
				p.et = {$urandom, $urandom};
				p.at = $urandom_range(0, 1) ? p.et : {$urandom, $urandom};
				p.el = oekm_pkg::len_t'($urandom_range(0, 15));
				p.al = $urandom_range(0, 1) ? p.el : oekm_pkg::len_t'($urandom_range(0, 15));
				return p;
			end
		endcase
		// swap roles now and then so edits hit either word
		if ($urandom_range(0, 1) == 0) begin
			p.et = {$urandom, $urandom};
			p.at = {$urandom, $urandom};
			for (int i = 0; i < n; i++) p.et[8*i +: 8] = eb[i];
			for (int i = 0; i < m; i++) p.at[8*i +: 8] = ab[i];
			p.el = code_length(n);
			p.al = code_length(m);
		end else begin
			p.et = {$urandom, $urandom};
			p.at = {$urandom, $urandom};
			for (int i = 0; i < m; i++) p.et[8*i +: 8] = ab[i];
			for (int i = 0; i < n; i++) p.at[8*i +: 8] = eb[i];
			p.el = code_length(m);
			p.al = code_length(n);
		end
		return p;
	endfunction

	initial begin
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.expected_text   <= '0;
		req_ch.expected_length <= '0;
		req_ch.actual_text     <= '0;
		req_ch.actual_length   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_words("", "");
		send_words("", "k");
		send_words("a", "");
		send_words("hello", "hello");
		send_words("lemon", "nemon");
		send_words("nap", "lap");
		send_words("fun", "hun");
		send_words("hat", "fat");
		send_words("gap", "bap");
		send_words("azure", "zzure");
		send_words("quip", "puip");
		send_words("qa", "za");
		send_words("ASK", "SSK");
		send_words("form", "from");
		send_words("abcd", "dbca");
		send_words("planet", "plant");
		send_words("plant", "planet");
		send_words("keyboard", "keyboar");
		send_words("abcdef", "abef");
		send_words("abcde", "xbcdy");
		send_raw('1, 4'hF, '1, 4'hF);
		send_raw('0, 4'd8, '0, 4'hF);
		send_raw('0, 4'hF, '1, 4'd8);
		send_raw(64'h0123_4567_89AB_CDEF, 4'd3, 64'hFEDC_BA98_7665_CDEF, 4'd3);
		send_raw(pack_text("abcdefgh"), 4'd8, 64'h6867_6665_6463_6261, 4'd12);
		wait_drained();

		for (int k = 0; k < RANDOM_REQS; k++) begin
			if (k % 40 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			if (k >= RANDOM_REQS - 100)
				idling_on = 1'b0;
			if (k == 200) begin
				// long output stall while requests keep coming
				long_hold_due = 1'b1;
				for (int j = 0; j < 12; j++)
					drive_request(make_pair());
				wait_drained();
			end
			if (k == 400)
				wait_drained();
			drive_request(make_pair());
			maybe_gap();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending_relations.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
